[rtl/pcd_pkg.sv]
// pcd_pkg: shared types, codes and helper functions for the png chunk deframer
// no dependencies; imported by png_chunk_deframer_core
`default_nettype none

package pcd_pkg;

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PH_SIG  = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_TYPE = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CRC  = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_HALT = 7'b1000000
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_PAL_LEN = 2'd3;

  // chunk kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_IHDR  = 3'd1;
  localparam logic [2:0] KIND_PLTE  = 3'd2;
  localparam logic [2:0] KIND_IDAT  = 3'd3;
  localparam logic [2:0] KIND_IEND  = 3'd4;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam int unsigned OUT_DATA_W = 224;

  // quotient digit and remainder of one base-256 step of a divide by three
  typedef struct packed {
    logic [7:0] q;
    logic [1:0] r;
  } div3_t;

  // file signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      3'd7:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] kind_of(input logic [31:0] t);
    logic [2:0] k;
    if (t == TYPE_IHDR)      k = KIND_IHDR;
    else if (t == TYPE_PLTE) k = KIND_PLTE;
    else if (t == TYPE_IDAT) k = KIND_IDAT;
    else if (t == TYPE_IEND) k = KIND_IEND;
    else                     k = KIND_OTHER;
    return k;
  endfunction

  // (rem * 256 + b) / 3 with rem < 3: value below 768, reciprocal 683 / 2048 is exact there
  function automatic div3_t div3_step(input logic [1:0] rem, input logic [7:0] b);
    logic [9:0]  x;
    logic [19:0] prod;
    logic [9:0]  back;
    div3_t       res;
    x     = {rem, b};
    prod  = {10'd0, x} * 20'd683;
    res.q = prod[18:11];
    back  = {2'd0, res.q} * 10'd3;
    res.r = 2'(x - back);
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/png_chunk_deframer_core.sv]
// png_chunk_deframer_core: byte-stream png chunk deframer, one byte per cycle while the result side takes its transfers
// depends on pcd_pkg
`default_nettype none

// channel   dir  ports                               transfer
// input     in   in_tvalid/in_tready/in_tdata/tuser  one file byte, tuser = start of file
// result    out  out_tvalid/out_tready/tdata/tuser   one chunk report (or signature error)
//
// every byte is captured in the input register, then the parser logic updates the
// state and may load the result register when the byte moves on out of that register
// throughput is one byte per cycle while the result side takes its transfers
// a stalled result holds the input register; an input byte is taken whenever
// that register is empty or moves on in the same cycle
// rst_n is synchronous, active low, and returns the parser to the signature phase;
// a byte with in_tuser high does the same before it is parsed

module png_chunk_deframer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tuser,   // [0] file_start
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] chunk_length, [63:32] chunk_type, [95:64] chunk_crc,
  // [126:96] palette_entries, [158:127] image_width, [190:159] image_height,
  // [198:191] bit_depth, [206:199] colour_type, [214:207] filter_method,
  // [222:215] interlace_method, [223] zero
  output      logic [pcd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output      logic [4:0]                      out_tuser   // [1:0] status, [4:2] chunk_kind
);
  import pcd_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_go;

  // parser state
  phase_t      phase_r, phase_nxt, cur_phase;
  logic [31:0] cnt_r, cnt_nxt, cur_cnt, cnt_inc;
  logic [31:0] len_r, len_nxt, cur_len;
  logic [31:0] type_r, type_nxt, cur_type;
  logic [31:0] crc_r, crc_nxt, cur_crc;
  logic [31:0] quo_r, quo_nxt, cur_quo;     // running length / 3
  logic [1:0]  rem_r, rem_nxt, cur_rem;     // running length % 3
  logic        sig_ok_r, sig_ok_nxt, cur_sig_ok;
  logic [31:0] width_r, width_nxt, cur_width;
  logic [31:0] height_r, height_nxt, cur_height;
  logic [7:0]  depth_r, depth_nxt, cur_depth;
  logic [7:0]  ctype_r, ctype_nxt, cur_ctype;
  logic [7:0]  filt_r, filt_nxt, cur_filt;
  logic [7:0]  ilace_r, ilace_nxt, cur_ilace;
  div3_t       dstep;

  // result
  logic        emit;
  logic [1:0]  e_status;
  logic [2:0]  e_kind;
  logic [31:0] e_len, e_type, e_crc;
  logic [30:0] e_pal;
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [4:0]  out_user_r;

  // input register moves on when the result register is free or being emptied
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // state as seen by this byte: a file start restarts from the reset values
  always_comb begin
    if (s1_start_r) begin
      cur_phase  = PH_SIG;
      cur_cnt    = '0;
      cur_len    = '0;
      cur_type   = '0;
      cur_crc    = '0;
      cur_quo    = '0;
      cur_rem    = '0;
      cur_sig_ok = 1'b1;
      cur_width  = '0;
      cur_height = '0;
      cur_depth  = '0;
      cur_ctype  = '0;
      cur_filt   = '0;
      cur_ilace  = '0;
    end else begin
      cur_phase  = phase_r;
      cur_cnt    = cnt_r;
      cur_len    = len_r;
      cur_type   = type_r;
      cur_crc    = crc_r;
      cur_quo    = quo_r;
      cur_rem    = rem_r;
      cur_sig_ok = sig_ok_r;
      cur_width  = width_r;
      cur_height = height_r;
      cur_depth  = depth_r;
      cur_ctype  = ctype_r;
      cur_filt   = filt_r;
      cur_ilace  = ilace_r;
    end
  end

  assign cnt_inc = cur_cnt + 32'd1;
  assign dstep   = div3_step(cur_rem, s1_byte_r);

  always_comb begin
    phase_nxt  = cur_phase;
    cnt_nxt    = cur_cnt;
    len_nxt    = cur_len;
    type_nxt   = cur_type;
    crc_nxt    = cur_crc;
    quo_nxt    = cur_quo;
    rem_nxt    = cur_rem;
    sig_ok_nxt = cur_sig_ok;
    width_nxt  = cur_width;
    height_nxt = cur_height;
    depth_nxt  = cur_depth;
    ctype_nxt  = cur_ctype;
    filt_nxt   = cur_filt;
    ilace_nxt  = cur_ilace;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_kind     = KIND_OTHER;
    e_len      = '0;
    e_type     = '0;
    e_crc      = '0;
    e_pal      = '0;

    case (cur_phase)
      PH_SIG: begin
        if (s1_byte_r != sig_byte(cur_cnt[2:0])) sig_ok_nxt = 1'b0;
        cnt_nxt = cnt_inc;
        if (cur_cnt[2:0] == 3'd7) begin
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
          if (!sig_ok_nxt) begin
            emit     = 1'b1;
            e_status = ST_BAD_SIG;
          end
        end
      end
      PH_LEN: begin
        // length and its divide by three are built a byte at a time
        len_nxt = {cur_len[23:0], s1_byte_r};
        quo_nxt = {cur_quo[23:0], dstep.q};
        rem_nxt = dstep.r;
        cnt_nxt = cnt_inc;
        if (cur_cnt[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt = {cur_type[23:0], s1_byte_r};
        cnt_nxt  = cnt_inc;
        if (cur_cnt[1:0] == 2'd3) begin
          cnt_nxt = '0;
          if (cur_len == '0 && type_nxt != TYPE_IEND) begin
            // empty chunk other than the end marker stops the parser
            phase_nxt = PH_HALT;
            emit      = 1'b1;
            e_status  = ST_ZERO_LEN;
            e_kind    = kind_of(type_nxt);
            e_type    = type_nxt;
          end else begin
            if (type_nxt == TYPE_IHDR) begin
              width_nxt  = '0;
              height_nxt = '0;
              depth_nxt  = '0;
              ctype_nxt  = '0;
              filt_nxt   = '0;
              ilace_nxt  = '0;
            end
            phase_nxt = (cur_len == '0) ? PH_CRC : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (cur_type == TYPE_IHDR) begin
          if (cur_cnt < 32'd4)       width_nxt  = {cur_width[23:0], s1_byte_r};
          else if (cur_cnt < 32'd8)  height_nxt = {cur_height[23:0], s1_byte_r};
          else if (cur_cnt == 32'd8)  depth_nxt = s1_byte_r;
          else if (cur_cnt == 32'd9)  ctype_nxt = s1_byte_r;
          else if (cur_cnt == 32'd11) filt_nxt  = s1_byte_r;
          else if (cur_cnt == 32'd12) ilace_nxt = s1_byte_r;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == cur_len) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_nxt = {cur_crc[23:0], s1_byte_r};
        cnt_nxt = cnt_inc;
        if (cur_cnt[1:0] == 2'd3) begin
          cnt_nxt = '0;
          emit    = 1'b1;
          e_kind  = kind_of(cur_type);
          e_len   = cur_len;
          e_type  = cur_type;
          e_crc   = crc_nxt;
          if (e_kind == KIND_PLTE) begin
            e_pal = cur_quo[30:0];
            if (cur_rem != 2'd0) e_status = ST_PAL_LEN;
          end
          phase_nxt = (e_kind == KIND_IEND) ? PH_DONE : PH_LEN;
          len_nxt   = '0;
          type_nxt  = '0;
          crc_nxt   = '0;
          quo_nxt   = '0;
          rem_nxt   = '0;
        end
      end
      default: begin
        // done or halted: bytes are dropped until the next file start
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      cnt_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      crc_r    <= '0;
      quo_r    <= '0;
      rem_r    <= '0;
      sig_ok_r <= 1'b1;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      ctype_r  <= '0;
      filt_r   <= '0;
      ilace_r  <= '0;
    end else if (s1_go) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      crc_r    <= crc_nxt;
      quo_r    <= quo_nxt;
      rem_r    <= rem_nxt;
      sig_ok_r <= sig_ok_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      ctype_r  <= ctype_nxt;
      filt_r   <= filt_nxt;
      ilace_r  <= ilace_nxt;
    end
  end

  // result register; image fields are the values current at this byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && emit) begin
      out_data_r <= {1'b0, ilace_nxt, filt_nxt, ctype_nxt, depth_nxt,
                     height_nxt, width_nxt, e_pal, e_crc, e_type, e_len};
      out_user_r <= {e_kind, e_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for png_chunk_deframer_core, one byte per in_ transfer
// depends on pcd_pkg and the core; predicts each chunk report from the byte stream
`timescale 1ns / 1ps

module tb;
  import pcd_pkg::*;

  // one expected chunk report, fields as the core reports them
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [31:0] length;
    logic [31:0] ctype;
    logic [31:0] crc;
    logic [30:0] pal;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [7:0]  colour;
    logic [7:0]  filter;
    logic [7:0]  interlace;
  } chunk_report_t;

  // byte-level parser prediction plus the queue of chunk reports still owed
  class chunk_report_sb;
    logic [63:0]   sig_ref;
    phase_t        ph;
    int unsigned   cnt;
    logic [31:0]   len_w, type_w, crc_w, width_w, height_w;
    logic [7:0]    hdr [5];
    bit            sig_good;
    chunk_report_t pending [$];
    int unsigned   reports, errors, parsed;
    int unsigned   by_status [4];

    function new();
      sig_ref = 64'h8950_4E47_0D0A_1A0A;
      reports = 0;
      errors  = 0;
      parsed  = 0;
      foreach (by_status[i]) by_status[i] = 0;
      clear();
    endfunction

    function void clear();
      ph       = PH_SIG;
      cnt      = 0;
      len_w    = '0;
      type_w   = '0;
      crc_w    = '0;
      width_w  = '0;
      height_w = '0;
      sig_good = 1'b1;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function logic [2:0] kind_for(logic [31:0] t);
      case (t)
        TYPE_IHDR: return KIND_IHDR;
        TYPE_PLTE: return KIND_PLTE;
        TYPE_IDAT: return KIND_IDAT;
        TYPE_IEND: return KIND_IEND;
        default:   return KIND_OTHER;
      endcase
    endfunction

    function void push(logic [1:0] st, logic [2:0] kd, logic [31:0] ln,
                       logic [31:0] ty, logic [31:0] cr, logic [30:0] pal);
      chunk_report_t r;
      r.status    = st;
      r.kind      = kd;
      r.length    = ln;
      r.ctype     = ty;
      r.crc       = cr;
      r.pal       = pal;
      r.width     = width_w;
      r.height    = height_w;
      r.depth     = hdr[0];
      r.colour    = hdr[1];
      r.filter    = hdr[3];
      r.interlace = hdr[4];
      pending = {pending, r};
    endfunction

    // one accepted byte
    function void note_byte(logic [7:0] b, bit start);
      logic [2:0]  kd;
      logic [1:0]  st;
      logic [30:0] pal;
      if (start) clear();
      if (ph != PH_HALT && ph != PH_DONE) parsed++;
      case (ph)
        PH_SIG: begin
          if (b != sig_ref[63 - 8 * cnt -: 8]) sig_good = 1'b0;
          cnt++;
          if (cnt == 8) begin
            cnt = 0;
            ph  = PH_LEN;
            if (!sig_good) push(ST_BAD_SIG, KIND_OTHER, '0, '0, '0, '0);
          end
        end
        PH_LEN: begin
          len_w = {len_w[23:0], b};
          cnt++;
          if (cnt == 4) begin
            cnt = 0;
            ph  = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_w = {type_w[23:0], b};
          cnt++;
          if (cnt == 4) begin
            cnt = 0;
            if (len_w == 0 && type_w != TYPE_IEND) begin
              // empty chunk other than IEND stops the parser
              push(ST_ZERO_LEN, kind_for(type_w), '0, type_w, '0, '0);
              ph = PH_HALT;
            end else begin
              if (type_w == TYPE_IHDR) begin
                width_w  = '0;
                height_w = '0;
                foreach (hdr[i]) hdr[i] = '0;
              end
              ph = (len_w == 0) ? PH_CRC : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (type_w == TYPE_IHDR) begin
            if (cnt < 4)       width_w  = {width_w[23:0], b};
            else if (cnt < 8)  height_w = {height_w[23:0], b};
            else if (cnt < 13) hdr[cnt - 8] = b;
          end
          cnt++;
          if (cnt == len_w) begin
            cnt = 0;
            ph  = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_w = {crc_w[23:0], b};
          cnt++;
          if (cnt == 4) begin
            cnt = 0;
            kd  = kind_for(type_w);
            st  = ST_OK;
            pal = '0;
            if (kd == KIND_PLTE) begin
              pal = 31'(len_w / 3);
              if (len_w % 3 != 0) st = ST_PAL_LEN;
            end
            push(st, kd, len_w, type_w, crc_w, pal);
            ph     = (kd == KIND_IEND) ? PH_DONE : PH_LEN;
            len_w  = '0;
            type_w = '0;
            crc_w  = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("report %0d %s: got %h, expected %h", reports, name, got, want));
    endtask

    // one result transfer
    task check_report(logic [OUT_DATA_W-1:0] d, logic [4:0] u);
      chunk_report_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d kind %0d type %h",
                         u[1:0], u[4:2], d[63:32]));
        return;
      end
      want = pending.pop_front();
      reports++;
      by_status[want.status]++;
      field_check("status", 32'(u[1:0]), 32'(want.status));
      field_check("chunk_kind", 32'(u[4:2]), 32'(want.kind));
      field_check("chunk_length", d[31:0], want.length);
      field_check("chunk_type", d[63:32], want.ctype);
      field_check("chunk_crc", d[95:64], want.crc);
      field_check("palette_entries", 32'(d[126:96]), 32'(want.pal));
      field_check("image_width", d[158:127], want.width);
      field_check("image_height", d[190:159], want.height);
      field_check("bit_depth", 32'(d[198:191]), 32'(want.depth));
      field_check("colour_type", 32'(d[206:199]), 32'(want.colour));
      field_check("filter_method", 32'(d[214:207]), 32'(want.filter));
      field_check("interlace_method", 32'(d[222:215]), 32'(want.interlace));
      field_check("pad bit", 32'(d[223]), 32'd0);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [4:0]            out_tuser;

  chunk_report_sb sb;
  bit             in_idle;
  int unsigned    bytes_sent;
  int unsigned    files;

  png_chunk_deframer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // 00 and ff one time in ten each, otherwise any value
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!in_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // one input transfer, with an optional idle gap ahead of it
  task automatic send_byte(input logic [7:0] b, input bit start);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, start);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8 * i +: 8], 1'b0);
  endtask

  task automatic send_sig(input bit corrupt);
    int unsigned pos;
    logic [7:0]  b;
    pos = $urandom_range(0, 7);
    for (int unsigned i = 0; i < 8; i++) begin
      b = sb.sig_ref[63 - 8 * i -: 8];
      if (corrupt && i == pos) b ^= 8'($urandom_range(1, 255));
      send_byte(b, i == 0);
    end
    files++;
  endtask

  // header, payload and crc; an empty non-IEND chunk stops after its type
  task automatic send_chunk(input logic [31:0] len, input logic [31:0] ty);
    send_word(len);
    send_word(ty);
    if (len == 0 && ty != TYPE_IEND) return;
    for (int unsigned i = 0; i < len; i++) send_byte(rand_byte(), 1'b0);
    send_word(rand_word());
  endtask

  // hold off the sender until every pending report has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // mostly well-formed files with random content, some noise and broken ones
  task automatic random_file();
    int unsigned n, r;
    logic [31:0] len, ty;
    in_idle = ($urandom_range(0, 3) != 0);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // plain noise from a file start
      n = $urandom_range(4, 40);
      for (int unsigned i = 0; i < n; i++) send_byte(rand_byte(), i == 0);
      files++;
      return;
    end
    send_sig(r < 16);
    if ($urandom_range(0, 9) != 0) begin
      // short, exact and overlong ihdr
      len = ($urandom_range(0, 4) != 0) ? 32'd13 : 32'($urandom_range(0, 20));
      send_chunk(len, TYPE_IHDR);
      if (len == 0) return;
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        ty  = TYPE_PLTE;
        len = ($urandom_range(0, 4) != 0) ? 32'(3 * $urandom_range(1, 12))
                                          : 32'($urandom_range(1, 20));
      end else if (r < 60) begin
        ty  = TYPE_IDAT;
        len = $urandom_range(1, 24);
      end else if (r < 70) begin
        ty  = TYPE_IHDR;
        len = 13;
      end else if (r < 92) begin
        ty  = rand_word();
        len = $urandom_range(1, 16);
      end else begin
        // empty chunk, halts the parser
        ty  = ($urandom_range(0, 1) != 0) ? TYPE_IDAT : rand_word();
        len = 0;
      end
      send_chunk(len, ty);
      if (len == 0 && ty != TYPE_IEND) return;
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_chunk(($urandom_range(0, 4) != 0) ? 32'd0 : 32'($urandom_range(1, 5)), TYPE_IEND);
      // trailing bytes after the end are ignored
      repeat ($urandom_range(0, 4)) send_byte(rand_byte(), 1'b0);
    end else if (r < 90) begin
      // cut off inside a chunk with an arbitrary, usually huge, length
      send_word(rand_word());
      send_word(rand_word());
      repeat ($urandom_range(0, 6)) send_byte(rand_byte(), 1'b0);
    end
  endtask

  // result side: random stalls, short and long, plus long open stretches
  initial begin
    int unsigned hold, r;
    out_tready = 1'b0;
    hold       = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready <= 1'b1;
          hold = $urandom_range(0, 15);
        end else if (r < 60) begin
          out_tready <= 1'b1;
          hold = $urandom_range(50, 300);
        end else if (r < 90) begin
          out_tready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_tready <= 1'b0;
          hold = $urandom_range(8, 60);
        end
      end
    end
  end

  // every result transfer is checked against the oldest pending report
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata, out_tuser);
  end

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    rst_n      = 1'b0;
    in_idle    = 1'b0;
    bytes_sent = 0;
    files      = 0;
    sb         = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // bad signature with ff and 00 bytes, then an empty IDAT halts the parser
    send_byte(8'hFF, 1'b1);
    for (int unsigned i = 1; i < 8; i++)
      send_byte((i == 4) ? 8'h00 : sb.sig_ref[63 - 8 * i -: 8], 1'b0);
    files++;
    send_word(32'h0);
    send_word(TYPE_IDAT);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // good signature, IEND carrying a payload byte, then a stray byte
    send_sig(1'b0);
    send_chunk(32'd1, TYPE_IEND);
    send_byte(8'hFF, 1'b0);
    wait_drained();

    while (sb.parsed < 750) begin
      random_file();
      if (files % 8 == 0) wait_drained();
    end

    // let the last reports out, then watch for anything extra
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d files, %0d bytes (%0d parsed), %0d chunk reports checked",
             files, bytes_sent, sb.parsed, sb.reports);
    $display("reports: %0d ok, %0d bad signature, %0d empty-chunk halt, %0d palette length",
             sb.by_status[ST_OK], sb.by_status[ST_BAD_SIG], sb.by_status[ST_ZERO_LEN],
             sb.by_status[ST_PAL_LEN]);
    if (sb.errors == 0) begin
      $display("png_chunk_deframer_core test passed");
    end else begin
      $display("png_chunk_deframer_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("png_chunk_deframer_core test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/pcd_pkg.sv
rtl/png_chunk_deframer_core.sv
tb/tb.sv
